// ===== rtl/core/affine_window_bilinear_warp_defines.svh =====
`ifndef AFFINE_WINDOW_BILINEAR_WARP_DEFINES_SVH
`define AFFINE_WINDOW_BILINEAR_WARP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define AWBW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define AWBW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/awbw_pkg.sv =====
package awbw_pkg;

  localparam int WIN_RAD    = 8;
  localparam int MASK_RAD   = 4;
  localparam int WIN_DIM    = 2 * WIN_RAD + 1;
  localparam int BANK_DIM   = WIN_RAD + 1;
  localparam int BANK_DEPTH = BANK_DIM * BANK_DIM;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int NBANK      = 4;
  localparam int COORD_W    = $clog2(WIN_DIM + 1);

  localparam int IDX_W  = 5;
  localparam int PIX_W  = 8;
  localparam int MPOS_W = 4;
  localparam int COEF_W = 16;
  localparam int STAT_W = 2;
  localparam int REG_W  = 2;
  localparam int FRAC_W = 12;
  localparam int ONE_Q  = 1 << FRAC_W;

  localparam int X_W   = MPOS_W + 1;
  localparam int P_W   = X_W + COEF_W;
  localparam int T_W   = P_W + 2;
  localparam int F_W   = T_W - FRAC_W;
  localparam int W_W   = 2 * FRAC_W + 1;
  localparam int M_W   = W_W + PIX_W;
  localparam int ACC_W = M_W + 2;
  localparam int PR_W  = 2 * COEF_W;
  localparam int DET_W = PR_W + 1;

  localparam longint DET_LO = longint'(1) << (2 * FRAC_W - 1);
  localparam longint DET_HI = longint'(1) << (2 * FRAC_W + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WARP = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_REJECT  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_LOAD    = 2'd3
  } awbw_status_t;

  typedef enum logic [REG_W-1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2,
    REG_COEF_D = 2'd3
  } awbw_reg_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [PIX_W-1:0]   data;
  } awbw_wr_t;

  // Entry of a window coordinate inside its parity bank.
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col);
    logic [COORD_W-2:0] rh;
    logic [COORD_W-2:0] ch;
    rh = row[COORD_W-1:1];
    ch = col[COORD_W-1:1];
    return BANK_AW'(rh * BANK_DIM) + BANK_AW'(ch);
  endfunction

endpackage

// ===== rtl/core/awbw_bank.sv =====
module awbw_bank (
  input  logic                         clk,
  input  awbw_pkg::awbw_wr_t           wr,
  input  logic                         rd_en,
  input  logic [awbw_pkg::BANK_AW-1:0] rd_addr,
  output logic [awbw_pkg::PIX_W-1:0]   rd_data
);
  import awbw_pkg::*;

  logic [PIX_W-1:0] mem [BANK_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/affine_window_bilinear_warp.sv =====
// An accepted transaction moves through the registered pipeline stages to the output.
// Throughput: one transaction per cycle while out_stall is low; the window is split into
// four parity banks, so the four bilinear samples come from four single-port reads in the same cycle.
// Reset (synchronous, active low) clears the pipeline valid bits and loads the
// identity transform; the window store is not cleared and holds garbage until loaded.
`include "affine_window_bilinear_warp_defines.svh"

module affine_window_bilinear_warp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [awbw_pkg::REG_W-1:0]  cfg_index,
  input  logic [awbw_pkg::COEF_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [awbw_pkg::IDX_W-1:0]  in_first_index,
  input  logic [awbw_pkg::IDX_W-1:0]  in_second_index,
  input  logic [awbw_pkg::PIX_W-1:0]  in_pixel_in,
  input  logic [awbw_pkg::MPOS_W-1:0] in_out_first,
  input  logic [awbw_pkg::MPOS_W-1:0] in_out_second,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [awbw_pkg::PIX_W-1:0]  out_pixel_out,
  output logic [awbw_pkg::STAT_W-1:0] out_status
);
  import awbw_pkg::*;

  logic signed [COEF_W-1:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic signed [PR_W-1:0]   ad_r, bc_r;
  logic signed [DET_W-1:0]  det;
  logic                     rej_r;

  logic en1, en2, en3, en4, en5, en6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // Stage 1
  logic signed [X_W-1:0] x1, x2;
  logic signed [P_W-1:0] pa1_nxt, pb1_nxt, pc1_nxt, pd1_nxt;
  logic signed [P_W-1:0] pa1_r, pb1_r, pc1_r, pd1_r;
  logic                  cmd1_r;
  logic [IDX_W-1:0]      li1_r, lj1_r;
  logic [PIX_W-1:0]      lpix1_r;

  // Stage 2
  logic signed [T_W-1:0] t1_r, t2_r;
  logic                  cmd2_r;
  logic [IDX_W-1:0]      li2_r, lj2_r;
  logic [PIX_W-1:0]      lpix2_r;

  // Stage 3
  logic signed [F_W-1:0] f1, f2;
  logic [FRAC_W-1:0]     r1, r2;
  logic                  ok, lin;
  awbw_status_t          status3_nxt, status3_r;
  logic [COORD_W-1:0]    row3_nxt, col3_nxt, row3_r, col3_r;
  logic [FRAC_W-1:0]     r1_3_r, r2_3_r;
  logic [PIX_W-1:0]      lpix3_r;
  logic                  wen3_r;

  // Stage 4
  logic [COORD_W-1:0]    brow [NBANK];
  logic [COORD_W-1:0]    bcol [NBANK];
  logic [BANK_AW-1:0]    rd_addr [NBANK];
  logic [PIX_W-1:0]      rd_data [NBANK];
  awbw_wr_t              wr [NBANK];
  logic [NBANK-1:0]      bank_we;
  logic [FRAC_W:0]       om1, om2, rr1, rr2;
  logic [W_W-1:0]        w_nxt [NBANK];
  logic [W_W-1:0]        w_r [NBANK];
  awbw_status_t          status4_r;
  logic                  p1_4_r, p2_4_r, use1_4_r, use2_4_r;

  // Stage 5
  logic [1:0]            bk [NBANK];
  logic [PIX_W-1:0]      px [NBANK];
  logic [M_W-1:0]        m_nxt [NBANK];
  logic [M_W-1:0]        m_r [NBANK];
  awbw_status_t          status5_r;

  // Stage 6
  logic [ACC_W-1:0]      acc;
  logic [PIX_W-1:0]      pix6_r;
  awbw_status_t          status6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= COEF_W'(ONE_Q);
      coef_b_r <= '0;
      coef_c_r <= '0;
      coef_d_r <= COEF_W'(ONE_Q);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A: coef_a_r <= cfg_data;
        REG_COEF_B: coef_b_r <= cfg_data;
        REG_COEF_C: coef_c_r <= cfg_data;
        REG_COEF_D: coef_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The determinant check follows the coefficients through the ad_r/bc_r products and the rej_r register.
  assign det = DET_W'(ad_r) - DET_W'(bc_r);

  always_ff @(posedge clk) begin
    ad_r  <= PR_W'(coef_a_r) * PR_W'(coef_d_r);
    bc_r  <= PR_W'(coef_b_r) * PR_W'(coef_c_r);
    rej_r <= (det > DET_HI) || (det < -DET_HI) || ((det > -DET_LO) && (det < DET_LO));
  end

  assign en6 = !v6_r || !out_stall;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_comb begin
    x1 = X_W'(in_out_first) - X_W'(MASK_RAD);
    x2 = X_W'(in_out_second) - X_W'(MASK_RAD);
    pa1_nxt = P_W'(x1) * P_W'(coef_a_r);
    pb1_nxt = P_W'(x2) * P_W'(coef_b_r);
    pc1_nxt = P_W'(x1) * P_W'(coef_c_r);
    pd1_nxt = P_W'(x2) * P_W'(coef_d_r);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pa1_r   <= pa1_nxt;
      pb1_r   <= pb1_nxt;
      pc1_r   <= pc1_nxt;
      pd1_r   <= pd1_nxt;
      cmd1_r  <= in_cmd;
      li1_r   <= in_first_index;
      lj1_r   <= in_second_index;
      lpix1_r <= in_pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      t1_r    <= T_W'(pa1_r) + T_W'(pb1_r) + T_W'(WIN_RAD * ONE_Q);
      t2_r    <= T_W'(pc1_r) + T_W'(pd1_r) + T_W'(WIN_RAD * ONE_Q);
      cmd2_r  <= cmd1_r;
      li2_r   <= li1_r;
      lj2_r   <= lj1_r;
      lpix2_r <= lpix1_r;
    end
  end

  always_comb begin
    f1  = t1_r[T_W-1:FRAC_W];
    f2  = t2_r[T_W-1:FRAC_W];
    r1  = t1_r[FRAC_W-1:0];
    r2  = t2_r[FRAC_W-1:0];
    ok  = (f1 >= 0) && (f1 < WIN_DIM) && (f2 >= 0) && (f2 < WIN_DIM) &&
          ((r1 == '0) || (f1 < WIN_DIM - 1)) && ((r2 == '0) || (f2 < WIN_DIM - 1));
    lin = (li2_r < WIN_DIM) && (lj2_r < WIN_DIM);
    row3_nxt = '0;
    col3_nxt = '0;
    if (cmd2_r != CMD_WARP) begin
      status3_nxt = ST_LOAD;
      if (lin) begin
        row3_nxt = COORD_W'(li2_r);
        col3_nxt = COORD_W'(lj2_r);
      end
    end else if (rej_r) begin
      status3_nxt = ST_REJECT;
    end else if (!ok) begin
      status3_nxt = ST_OUTSIDE;
    end else begin
      status3_nxt = ST_OK;
      row3_nxt    = COORD_W'(f1);
      col3_nxt    = COORD_W'(f2);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      status3_r <= status3_nxt;
      row3_r    <= row3_nxt;
      col3_r    <= col3_nxt;
      r1_3_r    <= r1;
      r2_3_r    <= r2;
      lpix3_r   <= lpix2_r;
      wen3_r    <= (cmd2_r == CMD_LOAD) && lin;
    end
  end

  // Bank {p, q} holds the window entries whose row parity is p and column parity is q.
  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      brow[b]     = (row3_r[0] == b[1]) ? row3_r : row3_r + COORD_W'(1);
      bcol[b]     = (col3_r[0] == b[0]) ? col3_r : col3_r + COORD_W'(1);
      rd_addr[b]  = bank_addr(brow[b], bcol[b]);
      bank_we[b]  = v3_r && en4 && wen3_r && ({row3_r[0], col3_r[0]} == 2'(b));
      wr[b].en    = bank_we[b];
      wr[b].addr  = bank_addr(row3_r, col3_r);
      wr[b].data  = lpix3_r;
    end
    rr1 = {1'b0, r1_3_r};
    rr2 = {1'b0, r2_3_r};
    om1 = (FRAC_W + 1)'(ONE_Q) - rr1;
    om2 = (FRAC_W + 1)'(ONE_Q) - rr2;
    w_nxt[0] = om1 * om2;
    w_nxt[1] = om1 * rr2;
    w_nxt[2] = rr1 * om2;
    w_nxt[3] = rr1 * rr2;
  end

  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    awbw_bank u_bank (
      .clk     (clk),
      .wr      (wr[g]),
      .rd_en   (en4),
      .rd_addr (rd_addr[g]),
      .rd_data (rd_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      w_r       <= w_nxt;
      status4_r <= status3_r;
      p1_4_r    <= row3_r[0];
      p2_4_r    <= col3_r[0];
      use1_4_r  <= (r1_3_r != '0);
      use2_4_r  <= (r2_3_r != '0);
    end
  end

  // Sample {di, dj} sits in the bank whose parities are flipped by di and dj.
  always_comb begin
    for (int s = 0; s < NBANK; s++) begin
      bk[s]    = {p1_4_r ^ s[1], p2_4_r ^ s[0]};
      px[s]    = ((!s[1] || use1_4_r) && (!s[0] || use2_4_r)) ? rd_data[bk[s]] : '0;
      m_nxt[s] = w_r[s] * px[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      m_r       <= m_nxt;
      status5_r <= status4_r;
    end
  end

  assign acc = ACC_W'(m_r[0]) + ACC_W'(m_r[1]) + ACC_W'(m_r[2]) + ACC_W'(m_r[3]);

  always_ff @(posedge clk) begin
    if (en6) begin
      pix6_r    <= (status5_r == ST_OK) ? acc[2*FRAC_W +: PIX_W] : '0;
      status6_r <= status5_r;
    end
  end

  assign out_valid     = v6_r;
  assign out_pixel_out = pix6_r;
  assign out_status    = status6_r;

  `AWBW_ASSERT_IMPLY(a_zero_unless_ok, out_valid && (out_status != ST_OK), out_pixel_out == '0, "pixel is not zero on a failed transaction")
  `AWBW_ASSERT_IMPLY(a_empty_takes, !v1_r, !in_stall, "input stalled although the first stage is empty")
  `AWBW_ASSERT_IMPLY(a_one_bank_write, 1'b1, $onehot0(bank_we), "more than one bank written in a cycle")
  `AWBW_ASSERT_NEXT(a_load_ack, v3_r && en4 && wen3_r, v4_r && (status4_r == ST_LOAD), "stored load not acknowledged")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import awbw_pkg::*;

  localparam int WIN_ENTRIES = WIN_DIM * WIN_DIM;
  localparam int IDLE_PCT = 29;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CFG_SETTLE = 8;
  localparam int RANDOM_PHASES = 12;
  localparam longint DET_MIN = longint'(1) << (2 * FRAC_W - 1);
  localparam longint DET_MAX = longint'(1) << (2 * FRAC_W + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    awbw_status_t     status;
  } warp_result_t;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [PIX_W-1:0]  pixel_in;
    logic [MPOS_W-1:0] out_first;
    logic [MPOS_W-1:0] out_second;
  } request_t;

  typedef logic [3:0][COEF_W-1:0] coef_set_t;

  typedef struct packed {
    logic         is_cfg;
    coef_set_t    coefs;
    request_t     req;
    logic         typed;
    warp_result_t typed_res;
  } table_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [REG_W-1:0]  cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_LOAD;
  logic [IDX_W-1:0]  in_first_index = '0;
  logic [IDX_W-1:0]  in_second_index = '0;
  logic [PIX_W-1:0]  in_pixel_in = '0;
  logic [MPOS_W-1:0] in_out_first = '0;
  logic [MPOS_W-1:0] in_out_second = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  out_pixel_out;
  logic [STAT_W-1:0] out_status;

  logic [PIX_W-1:0] window_copy [WIN_ENTRIES];
  longint           transform [4] = '{ONE_Q, 0, 0, ONE_Q};
  warp_result_t     pending_results [$];
  table_row_t       directed_rows [$];
  int               error_count = 0;
  int               idle_cycles = 0;
  logic             stall_free = 1'b0;

  affine_window_bilinear_warp i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .in_pixel_in     (in_pixel_in),
    .in_out_first    (in_out_first),
    .in_out_second   (in_out_second),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_status      (out_status)
  );

  always #10 clk = ~clk;

  function automatic logic in_win_range(input longint v);
    return v >= 0 && v < WIN_DIM;
  endfunction

  function automatic longint window_at(input longint row, input longint col);
    return longint'(window_copy[row * WIN_DIM + col]);
  endfunction

  function automatic warp_result_t warp_or_load(input request_t r);
    warp_result_t res;
    longint det;
    longint x1;
    longint x2;
    longint t1;
    longint t2;
    longint f1;
    longint f2;
    longint r1;
    longint r2;
    longint acc;
    res.pixel = '0;
    res.status = ST_LOAD;
    if (r.cmd == CMD_LOAD) begin
      if (r.first_index < WIN_DIM && r.second_index < WIN_DIM) begin
        window_copy[r.first_index * WIN_DIM + r.second_index] = r.pixel_in;
      end
      return res;
    end
    det = transform[REG_COEF_A] * transform[REG_COEF_D]
        - transform[REG_COEF_B] * transform[REG_COEF_C];
    if (det < 0) begin
      det = -det;
    end
    if (det < DET_MIN || det > DET_MAX) begin
      res.status = ST_REJECT;
      return res;
    end
    x1 = longint'(r.out_first) - MASK_RAD;
    x2 = longint'(r.out_second) - MASK_RAD;
    t1 = x1 * transform[REG_COEF_A] + x2 * transform[REG_COEF_B] + WIN_RAD * ONE_Q;
    t2 = x1 * transform[REG_COEF_C] + x2 * transform[REG_COEF_D] + WIN_RAD * ONE_Q;
    r1 = t1 & (ONE_Q - 1);
    r2 = t2 & (ONE_Q - 1);
    f1 = (t1 - r1) / ONE_Q;
    f2 = (t2 - r2) / ONE_Q;
    if (!in_win_range(f1) || !in_win_range(f2) || (r1 != 0 && !in_win_range(f1 + 1))
        || (r2 != 0 && !in_win_range(f2 + 1))) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    acc = (ONE_Q - r1) * (ONE_Q - r2) * window_at(f1, f2);
    if (r2 != 0) begin
      acc += (ONE_Q - r1) * r2 * window_at(f1, f2 + 1);
    end
    if (r1 != 0) begin
      acc += r1 * (ONE_Q - r2) * window_at(f1 + 1, f2);
    end
    if (r1 != 0 && r2 != 0) begin
      acc += r1 * r2 * window_at(f1 + 1, f2 + 1);
    end
    res.pixel = PIX_W'(acc >>> (2 * FRAC_W));
    res.status = ST_OK;
    return res;
  endfunction

  function automatic void add_cfg(input int a, input int b, input int c, input int d);
    table_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.coefs[REG_COEF_A] = COEF_W'(a);
    row.coefs[REG_COEF_B] = COEF_W'(b);
    row.coefs[REG_COEF_C] = COEF_W'(c);
    row.coefs[REG_COEF_D] = COEF_W'(d);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_req(input logic cmd, input int first_index,
                                  input int second_index, input int pixel_in,
                                  input int out_first, input int out_second,
                                  input logic typed, input int pixel,
                                  input awbw_status_t status);
    table_row_t row;
    row = '0;
    row.req.cmd = cmd;
    row.req.first_index = IDX_W'(first_index);
    row.req.second_index = IDX_W'(second_index);
    row.req.pixel_in = PIX_W'(pixel_in);
    row.req.out_first = MPOS_W'(out_first);
    row.req.out_second = MPOS_W'(out_second);
    row.typed = typed;
    row.typed_res.pixel = PIX_W'(pixel);
    row.typed_res.status = status;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic coef_set_t random_transform(input int phase);
    coef_set_t coefs;
    longint det;
    int pick;
    pick = $urandom_range(0, 5);
    if (phase == 0) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 2))
          0: coefs[k] = 16'h7fff;
          1: coefs[k] = 16'h8000;
          default: coefs[k] = 16'h0000;
        endcase
      end
    end else if (phase == 1 || pick == 0) begin
      for (int k = 0; k < 4; k++) begin
        coefs[k] = COEF_W'($urandom());
      end
    end else begin
      do begin
        coefs[REG_COEF_A] = COEF_W'(int'($urandom_range(0, 16384)) - 8192);
        coefs[REG_COEF_B] = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
        coefs[REG_COEF_C] = COEF_W'(int'($urandom_range(0, 8192)) - 4096);
        coefs[REG_COEF_D] = COEF_W'(int'($urandom_range(0, 16384)) - 8192);
        det = longint'($signed(coefs[REG_COEF_A])) * longint'($signed(coefs[REG_COEF_D]))
            - longint'($signed(coefs[REG_COEF_B])) * longint'($signed(coefs[REG_COEF_C]));
        if (det < 0) begin
          det = -det;
        end
      end while (det < DET_MIN || det > DET_MAX);
    end
    return coefs;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.cmd = ($urandom_range(0, 99) < 25) ? CMD_LOAD : CMD_WARP;
    r.pixel_in = PIX_W'($urandom());
    if ($urandom_range(0, 99) < 90) begin
      r.first_index = IDX_W'($urandom_range(0, WIN_DIM - 1));
      r.second_index = IDX_W'($urandom_range(0, WIN_DIM - 1));
    end else begin
      r.first_index = IDX_W'($urandom());
      r.second_index = IDX_W'($urandom());
    end
    if ($urandom_range(0, 99) < 85) begin
      r.out_first = MPOS_W'($urandom_range(0, 2 * MASK_RAD));
      r.out_second = MPOS_W'($urandom_range(0, 2 * MASK_RAD));
    end else begin
      r.out_first = MPOS_W'($urandom());
      r.out_second = MPOS_W'($urandom());
    end
    return r;
  endfunction

  task automatic drive_request(input request_t r, input logic typed,
                               input warp_result_t typed_res);
    warp_result_t predicted;
    while (!stall_free && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_first_index <= r.first_index;
    in_second_index <= r.second_index;
    in_pixel_in <= r.pixel_in;
    in_out_first <= r.out_first;
    in_out_second <= r.out_second;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = warp_or_load(r);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
  endtask

  // The transform is only changed once every outstanding transaction has drained.
  task automatic set_transform(input coef_set_t coefs);
    awbw_reg_t reg_sel;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (CFG_SETTLE) @(posedge clk);
    reg_sel = reg_sel.first();
    repeat (reg_sel.num()) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_sel;
      cfg_data <= coefs[reg_sel];
      transform[reg_sel] = longint'($signed(coefs[reg_sel]));
      @(posedge clk);
      reg_sel = reg_sel.next();
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    warp_result_t expected_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: pixel_out %0d, status %0d", out_pixel_out, out_status);
        error_count++;
      end else begin
        expected_res = pending_results.pop_front();
        if (out_pixel_out !== expected_res.pixel) begin
          $error("pixel_out: expected %0d, actual %0d", expected_res.pixel, out_pixel_out);
          error_count++;
        end
        if (out_status !== expected_res.status) begin
          $error("status: expected %0d, actual %0d", expected_res.status, out_status);
          error_count++;
        end
      end
    end
    out_stall <= !stall_free && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[affine_window_bilinear_warp] ERROR");
      $finish;
    end
  end

  initial begin
    request_t fill_req;
    int phase_items;
    add_req(CMD_LOAD, 8, 8, 255, 0, 0, 1'b1, 0, ST_LOAD);
    add_req(CMD_LOAD, 0, 0, 0, 15, 15, 1'b1, 0, ST_LOAD);
    add_req(CMD_LOAD, 16, 16, 255, 9, 3, 1'b1, 0, ST_LOAD);
    add_req(CMD_LOAD, 31, 31, 170, 15, 0, 1'b1, 0, ST_LOAD);
    add_req(CMD_LOAD, 17, 0, 85, 0, 15, 1'b1, 0, ST_LOAD);
    add_req(CMD_LOAD, 0, 17, 85, 0, 0, 1'b1, 0, ST_LOAD);
    add_req(CMD_WARP, 31, 31, 255, 4, 4, 1'b1, 255, ST_OK);
    add_req(CMD_WARP, 0, 0, 0, 12, 12, 1'b1, 255, ST_OK);
    add_req(CMD_WARP, 0, 0, 0, 0, 0, 1'b0, 0, ST_OK);
    add_req(CMD_WARP, 16, 16, 0, 8, 8, 1'b0, 0, ST_OK);
    add_req(CMD_WARP, 0, 0, 0, 15, 4, 1'b1, 0, ST_OUTSIDE);
    add_req(CMD_WARP, 0, 0, 0, 4, 15, 1'b1, 0, ST_OUTSIDE);
    add_req(CMD_WARP, 0, 0, 0, 15, 15, 1'b1, 0, ST_OUTSIDE);
    add_cfg(2048, 0, 0, 4096);
    add_req(CMD_WARP, 0, 0, 0, 5, 5, 1'b0, 0, ST_OK);
    add_cfg(8192, 0, 0, 4096);
    add_req(CMD_WARP, 0, 0, 0, 8, 8, 1'b0, 0, ST_OK);
    add_req(CMD_WARP, 0, 0, 0, 0, 3, 1'b0, 0, ST_OK);
    add_req(CMD_WARP, 0, 0, 0, 9, 4, 1'b1, 0, ST_OUTSIDE);
    add_cfg(2047, 0, 0, 4096);
    add_req(CMD_WARP, 0, 0, 0, 4, 4, 1'b1, 0, ST_REJECT);
    add_cfg(8193, 0, 0, 4096);
    add_req(CMD_WARP, 0, 0, 0, 4, 4, 1'b1, 0, ST_REJECT);
    add_cfg(-32768, 32767, -32768, 32767);
    add_req(CMD_WARP, 0, 0, 0, 0, 0, 1'b1, 0, ST_REJECT);
    add_req(CMD_LOAD, 2, 3, 77, 0, 0, 1'b1, 0, ST_LOAD);
    add_cfg(0, 4096, -4096, 0);
    add_req(CMD_WARP, 0, 0, 0, 1, 6, 1'b0, 0, ST_OK);
    add_cfg(-4096, 0, 0, 6144);
    add_req(CMD_WARP, 0, 0, 0, 3, 3, 1'b0, 0, ST_OK);
    add_req(CMD_WARP, 0, 0, 0, 8, 0, 1'b0, 0, ST_OK);
    add_cfg(6144, 2048, 2048, 4096);
    add_req(CMD_WARP, 0, 0, 0, 5, 4, 1'b0, 0, ST_OK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Every window entry is written before the first warp can sample it.
    for (int row = 0; row < WIN_DIM; row++) begin
      for (int col = 0; col < WIN_DIM; col++) begin
        fill_req.cmd = CMD_LOAD;
        fill_req.first_index = IDX_W'(row);
        fill_req.second_index = IDX_W'(col);
        fill_req.pixel_in = PIX_W'($urandom());
        fill_req.out_first = MPOS_W'($urandom());
        fill_req.out_second = MPOS_W'($urandom());
        drive_request(fill_req, 1'b0, '0);
      end
    end

    foreach (directed_rows[n]) begin
      if (directed_rows[n].is_cfg) begin
        set_transform(directed_rows[n].coefs);
      end else begin
        drive_request(directed_rows[n].req, directed_rows[n].typed,
                      directed_rows[n].typed_res);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_transform(random_transform(phase));
      stall_free = (phase == 4);
      phase_items = $urandom_range(100, 140);
      repeat (phase_items) begin
        drive_request(random_request(), 1'b0, '0);
      end
    end
    stall_free = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[affine_window_bilinear_warp] OK");
    end else begin
      $display("[affine_window_bilinear_warp] ERROR");
    end
    $finish;
  end

endmodule
